// ----- rtl/core/rpu_pkg.sv -----
package rpu_pkg;

  // pack_mode register codes
  localparam logic [2:0] MODE_RAW12   = 3'd0;
  localparam logic [2:0] MODE_RAW10   = 3'd1;
  localparam logic [2:0] MODE_PACK12  = 3'd2;
  localparam logic [2:0] MODE_MIPI12  = 3'd3;
  localparam logic [2:0] MODE_SPACK12 = 3'd4;
  localparam logic [2:0] MODE_MIPI10  = 3'd5;

  // index of the final byte of a group
  localparam logic [2:0] LAST_PHASE_12 = 3'd2;
  localparam logic [2:0] LAST_PHASE_10 = 3'd4;

  // one finished group (or word) handed from front to back
  typedef struct packed {
    logic [2:0]      mode;
    logic [3:0][7:0] held;
    logic [15:0]     data;
  } rpu_job_t;

  // queue status seen by the front
  typedef struct packed {
    logic full;
    logic empty;
  } rpu_q_status_t;

endpackage

// ----- rtl/core/rpu_front.sv -----
module rpu_front
  import rpu_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic [2:0]    mode,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [15:0]   in_tdata,
  input  logic          in_tuser,
  input  rpu_q_status_t q_status,
  output logic          push,
  output rpu_job_t      job
);

  logic [2:0]      phase_r, phase_nxt;
  logic [3:0][7:0] held_r;
  logic [2:0]      phase_eff;
  logic [2:0]      last_phase;
  logic            accept;
  logic            hold_wr;

  assign in_tready  = !q_status.full;
  assign accept     = in_tvalid && in_tready;
  assign phase_eff  = in_tuser ? 3'd0 : phase_r;
  assign last_phase = (mode == MODE_MIPI10) ? LAST_PHASE_10 : LAST_PHASE_12;

  always_comb begin
    phase_nxt = phase_r;
    push      = 1'b0;
    hold_wr   = 1'b0;
    if (accept) begin
      unique case (mode) inside
        MODE_RAW12, MODE_RAW10: begin
          phase_nxt = 3'd0;
          push      = 1'b1;
        end
        MODE_PACK12, MODE_MIPI12, MODE_SPACK12, MODE_MIPI10: begin
          if (phase_eff < last_phase) begin
            hold_wr   = 1'b1;
            phase_nxt = phase_eff + 3'd1;
          end else begin
            phase_nxt = 3'd0;
            push      = 1'b1;
          end
        end
        default: phase_nxt = phase_eff;
      endcase
    end
  end

  assign job.mode = mode;
  assign job.held = held_r;
  assign job.data = in_tdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 3'd0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hold_wr) begin
      held_r[phase_eff[1:0]] <= in_tdata[7:0];
    end
  end

`ifndef ASSERT_OFF
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r <= LAST_PHASE_10)
    else $error("byte phase out of range");
`endif

endmodule

// ----- rtl/core/rpu_queue.sv -----
module rpu_queue
  import rpu_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpu_job_t      push_job,
  input  logic          pop,
  output rpu_job_t      pop_job,
  output rpu_q_status_t status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  rpu_job_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign pop_job      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

`ifndef ASSERT_OFF
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    status.full |-> !push || pop)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !status.empty)
    else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count out of range");
`endif

endmodule

// ----- rtl/core/rpu_back.sv -----
module rpu_back
  import rpu_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  rpu_q_status_t q_status,
  input  rpu_job_t      q_job,
  output logic          pop,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [15:0]   out_tdata,
  output logic          out_tlast
);

  rpu_job_t    cur_r;
  logic        cur_valid_r, cur_valid_nxt;
  logic [1:0]  idx_r, idx_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] pix_r;
  logic        last_r;

  logic [1:0]  last_idx;
  logic [15:0] pix;
  logic        slot_free;
  logic        emit;
  logic        cur_done;
  logic [7:0]  b4;

  assign b4 = cur_r.data[7:0];

  always_comb begin
    last_idx = 2'd1;
    if (cur_r.mode == MODE_RAW12 || cur_r.mode == MODE_RAW10) begin
      last_idx = 2'd0;
    end else if (cur_r.mode == MODE_MIPI10) begin
      last_idx = 2'd3;
    end
  end

  always_comb begin
    pix = '0;
    unique case (cur_r.mode) inside
      MODE_RAW12: pix = {cur_r.data[11:0], 4'b0};
      MODE_RAW10: pix = {cur_r.data[9:0], 6'b0};
      MODE_PACK12: begin
        pix = idx_r[0] ? {cur_r.data[7:0], cur_r.held[1][7:4], 4'b0}
                       : {cur_r.held[0], cur_r.held[1][3:0], 4'b0};
      end
      MODE_MIPI12: begin
        pix = idx_r[0] ? {cur_r.held[1], cur_r.data[7:4], 4'b0}
                       : {cur_r.held[0], cur_r.data[3:0], 4'b0};
      end
      MODE_SPACK12: begin
        pix = idx_r[0] ? {cur_r.data[7:0], cur_r.held[1][7:4], 4'b0}
                       : {cur_r.held[1][3:0], cur_r.held[0], 4'b0};
      end
      MODE_MIPI10: begin
        // pixel i takes its two low bits from bits 2i+1..2i of the fifth byte
        pix = {cur_r.held[idx_r], b4[{idx_r, 1'b1}], b4[{idx_r, 1'b0}], 6'b0};
      end
      default: pix = '0;
    endcase
  end

  assign slot_free = !out_valid_r || out_tready;
  assign emit      = cur_valid_r && slot_free;
  assign cur_done  = emit && (idx_r == last_idx);
  assign pop       = !q_status.empty && (!cur_valid_r || cur_done);

  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 2'd1;
    end
    out_valid_nxt = emit ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_job;
    end
    if (emit) begin
      pix_r  <= pix;
      last_r <= (idx_r == last_idx);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = pix_r;
  assign out_tlast  = last_r;

`ifndef ASSERT_OFF
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> idx_r <= last_idx)
    else $error("pixel index past end of group");
`endif

endmodule

// ----- rtl/core/raw_pixel_unpack_to_16bit_top.sv -----
// Raw camera line unpacker. Each input transaction carries one 16-bit word
// (raw12/raw10 word modes) or one byte in tdata[7:0] (packed modes), with
// tuser marking the first word or byte of a line; a line start drops any
// partial byte group. Output transactions carry one 16-bit pixel, MSB aligned,
// with tlast set on the last pixel produced by a given input transaction.
// pack_mode (cfg port): 0 raw12 words, 1 raw10 words, 2 packed12, 3 mipi12,
// 4 spacked12, 5 mipi10; 6 and 7 produce nothing. Write it only while idle.
// Timing: one input transaction per cycle is accepted while the job queue
// has room; the front hands each completed group to a QUEUE_DEPTH-entry
// queue, and the back loads it into its current-group register before
// registering its first pixel. The back emits one pixel per cycle while the
// output is not stalled, so throughput is bounded by the pixel side: one
// word gives one pixel, three bytes give two, five bytes give four.
// No clearing pass after reset.
module raw_pixel_unpack_to_16bit_top
  import rpu_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data,     // pack_mode
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,     // [15:0] data
  input  logic        in_tuser,     // [0] line_start
  // pixel stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,    // [15:0] pixel
  output logic        out_tlast
);

  logic [2:0]    mode_r;
  logic          push;
  logic          pop;
  rpu_job_t      push_job;
  rpu_job_t      pop_job;
  rpu_q_status_t q_status;

  // mode register, always ready for a write transaction
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RAW12;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // front: byte phase tracking and group assembly
  rpu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_status  (q_status),
    .push      (push),
    .job       (push_job)
  );

  // short job queue decoupling byte intake from pixel output
  rpu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (q_status)
  );

  // back: one pixel per cycle into the output register while the output is not stalled
  rpu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_status   (q_status),
    .q_job      (pop_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
